FILE: design/rgs_pkg.sv
package rgs_pkg;

  localparam int DEPTH   = 1024;
  localparam int MAX_RUN = 64;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = 11;
  localparam int RUN_W  = 7;
  localparam int DATA_W = 64;
  // A run position can go past the widest index by up to MAX_RUN - 1.
  localparam int POS_W  = IDX_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  index;
    logic [RUN_W-1:0]  run_length;
    logic [DATA_W-1:0] data;
    logic              list_end;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_last;
    logic              list_last;
    logic              bad_index;
  } out_t;

  typedef struct packed {
    logic run_last;
    logic list_last;
    logic bad_index;
  } meta_t;

endpackage

FILE: design/rgs_out_queue.sv
module rgs_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rgs_pkg::out_t push_word,
  output logic [1:0]    occ,
  output logic          out_valid,
  input  logic          out_ready,
  output rgs_pkg::out_t out_data
);
  import rgs_pkg::*;

  out_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign occ       = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

FILE: design/ranged_gather_scatter.sv
// Ranged gather/scatter over a 1024 x 64-bit single-port word store with
// 1-based positions. A write word is accepted and stored at once; it gives
// no result. A read word of run length L (0 selects cfg default_run, clamped
// to 1..64) is accepted, then holds the input while one store read per cycle
// is issued when the output queue has room; the store has a single read port.
// Each read goes through the registered store output into a two-word output
// queue, so results stream at one word per cycle while out_ready is high and
// the input stays blocked only until the last read of the run is issued.
// Positions that are zero or past the store return zero with bad_index set;
// writes to them are dropped. Entries never written read back undefined.
module ranged_gather_scatter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rgs_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rgs_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [rgs_pkg::RUN_W-1:0] cfg_data
);
  import rgs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] ram_q;

  logic [RUN_W-1:0]  default_run_r;
  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [RUN_W-1:0]  left_r, left_nxt;
  logic              list_end_r, list_end_nxt;
  logic              infl_r;
  meta_t             meta_r, meta_nxt;

  logic              in_acc;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [RUN_W-1:0]  raw_len;
  logic [RUN_W-1:0]  run_len;
  logic              issue;
  logic              pos_ok;
  logic [POS_W-1:0]  pos_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0]        occ;
  logic [1:0]        used;
  logic              pop;
  out_t              push_word;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && in_ready;

  assign wr_en   = in_acc && (in_data.op == OP_WRITE) && (in_data.index != '0)
                   && (int'(in_data.index) <= DEPTH);
  assign wr_addr = ADDR_W'(in_data.index - IDX_W'(1));

  always_comb begin
    raw_len = (in_data.run_length != '0) ? in_data.run_length : default_run_r;
    if (raw_len == '0) begin
      run_len = RUN_W'(1);
    end else if (raw_len > RUN_W'(MAX_RUN)) begin
      run_len = RUN_W'(MAX_RUN);
    end else begin
      run_len = raw_len;
    end
  end

  // Issue a read only while the queue plus the word in flight has room.
  assign pop   = out_valid && out_ready;
  assign used  = occ + {1'b0, infl_r};
  assign issue = busy_r && ((used != 2'd2) || pop);

  assign pos_ok  = (pos_r != '0) && (int'(pos_r) <= DEPTH);
  assign pos_m1  = pos_r - POS_W'(1);
  assign rd_addr = ADDR_W'(pos_m1);

  always_comb begin
    busy_nxt     = busy_r;
    pos_nxt      = pos_r;
    left_nxt     = left_r;
    list_end_nxt = list_end_r;
    meta_nxt     = meta_r;
    if (in_acc && (in_data.op == OP_READ)) begin
      busy_nxt     = 1'b1;
      pos_nxt      = POS_W'(in_data.index);
      left_nxt     = run_len;
      list_end_nxt = in_data.list_end;
    end else if (issue) begin
      meta_nxt.run_last  = (left_r == RUN_W'(1));
      meta_nxt.list_last = (left_r == RUN_W'(1)) && list_end_r;
      meta_nxt.bad_index = !pos_ok;
      pos_nxt            = pos_r + POS_W'(1);
      left_nxt           = left_r - RUN_W'(1);
      busy_nxt           = (left_r != RUN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_run_r <= RUN_W'(1);
      busy_r        <= 1'b0;
      infl_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_run_r <= cfg_data;
      end
      busy_r <= busy_nxt;
      infl_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    left_r     <= left_nxt;
    list_end_r <= list_end_nxt;
    meta_r     <= meta_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.data;
    end
    if (issue && pos_ok) begin
      ram_q <= mem[rd_addr];
    end
  end

  always_comb begin
    push_word.value     = meta_r.bad_index ? '0 : ram_q;
    push_word.run_last  = meta_r.run_last;
    push_word.list_last = meta_r.list_last;
    push_word.bad_index = meta_r.bad_index;
  end

  rgs_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (infl_r),
    .push_word (push_word),
    .occ       (occ),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: tb/tb_ranged_gather_scatter.sv
module tb_ranged_gather_scatter;
  import rgs_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int MAX_IDX     = (1 << IDX_W) - 1;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              cfg_we    = 1'b0;
  logic [RUN_W-1:0]  cfg_data  = '0;

  // Stimulus side: words waiting to be driven, and which store entries they fill.
  in_t               stim_q[$];
  bit                filled [1:DEPTH];
  int                low_ptr  = 5;
  int                high_ptr = DEPTH - 3;
  int                snd_idle = 35;
  int                rcv_idle = 55;

  // Prediction side: its own copy of the store and of default_run.
  logic [DATA_W-1:0] store_copy [1:DEPTH];
  logic [RUN_W-1:0]  dflt_run = 7'd1;
  out_t              gathered_q[$];
  out_t              want;
  int                fail_count  = 0;
  int                stall_cycles = 0;

  ranged_gather_scatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int run_len(input logic [RUN_W-1:0] rl);
    logic [RUN_W-1:0] v;
    v = (rl != 0) ? rl : dflt_run;
    if (v == 0) return 1;
    if (v > MAX_RUN) return MAX_RUN;
    return int'(v);
  endfunction

  function automatic bit run_filled(input int start, input int len);
    int pos;
    for (int k = 0; k < len; k++) begin
      pos = start + k;
      if (pos >= 1 && pos <= DEPTH && !filled[pos]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic scatter_or_gather(input in_t it);
    int   len;
    int   pos;
    bit   ok;
    out_t w;
    if (it.op == OP_WRITE) begin
      if (it.index != 0 && it.index <= DEPTH) store_copy[it.index] = it.data;
    end else begin
      len = run_len(it.run_length);
      for (int k = 0; k < len; k++) begin
        pos = int'(it.index) + k;
        ok = (pos != 0) && (pos <= DEPTH);
        w.value     = ok ? store_copy[pos] : '0;
        w.run_last  = (k == len - 1);
        w.list_last = (k == len - 1) && it.list_end;
        w.bad_index = !ok;
        gathered_q.push_back(w);
      end
    end
  endtask

  task automatic push_word(input logic op, input int idx, input int rl,
                           input logic [DATA_W-1:0] d, input logic le);
    in_t it;
    it.op         = op;
    it.index      = idx[IDX_W-1:0];
    it.run_length = rl[RUN_W-1:0];
    it.data       = d;
    it.list_end   = le;
    if (op == OP_WRITE && idx >= 1 && idx <= DEPTH) filled[idx] = 1'b1;
    stim_q.push_back(it);
  endtask

  // Writes mostly grow two filled regions, one from each end of the store, so
  // that most reads find whole runs of written entries.
  task automatic rand_word();
    int r;
    int len_f;
    int start;
    bit found;
    r = $urandom_range(99, 0);
    if (r < 45) begin
      r = $urandom_range(99, 0);
      if (r < 35 && low_ptr < high_ptr) begin
        start = low_ptr;
        low_ptr++;
      end else if (r < 60 && high_ptr > low_ptr) begin
        start = high_ptr;
        high_ptr--;
      end else if (r < 85) begin
        start = $urandom_range(DEPTH, 1);
      end else begin
        start = ($urandom_range(1, 0) == 1) ? 0 : $urandom_range(MAX_IDX, DEPTH + 1);
      end
      push_word(OP_WRITE, start, $urandom_range(127, 0), {$urandom, $urandom},
                $urandom_range(9, 0) == 0);
    end else begin
      r = $urandom_range(99, 0);
      if (r < 20) len_f = 0;
      else if (r < 85) len_f = $urandom_range(12, 1);
      else if (r < 95) len_f = $urandom_range(MAX_RUN, 13);
      else len_f = $urandom_range(127, MAX_RUN + 1);
      found = 1'b0;
      for (int t = 0; t < 25 && !found; t++) begin
        r = $urandom_range(99, 0);
        if (r < 45) start = $urandom_range(low_ptr - 1, 0);
        else if (r < 90) start = $urandom_range(DEPTH + 8, high_ptr + 1);
        else start = $urandom_range(MAX_IDX, 0);
        found = run_filled(start, run_len(RUN_W'(len_f)));
      end
      // A run that lies wholly past the store is always safe to read.
      if (!found) start = $urandom_range(MAX_IDX, DEPTH + 1);
      push_word(OP_READ, start, len_f, {$urandom, $urandom}, $urandom_range(3, 0) == 0);
    end
  endtask

  task automatic wait_idle(input int extra);
    while (stim_q.size() != 0 || in_valid || gathered_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_default_run(input logic [RUN_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dflt_run = v;
    @(negedge clk);
  endtask

  task automatic random_phase(input int n, input logic [RUN_W-1:0] v,
                              input int snd, input int rcv);
    wait_idle(8);
    set_default_run(v);
    snd_idle = snd;
    rcv_idle = rcv;
    repeat (n) rand_word();
  endtask

  // Driver: a new word goes out only when the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 && $urandom_range(99, 0) >= snd_idle) begin
        in_valid <= 1'b1;
        in_data  <= stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) scatter_or_gather(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gathered_q.size() == 0) begin
        $display("%0t: unexpected result word value=%h run_last=%b list_last=%b bad_index=%b",
                 $time, out_data.value, out_data.run_last, out_data.list_last,
                 out_data.bad_index);
        fail_count++;
      end else begin
        want = gathered_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch: expected value=%h run_last=%b list_last=%b bad_index=%b",
                   $time, want.value, want.run_last, want.list_last, want.bad_index);
          $display("%0t:           actual   value=%h run_last=%b list_last=%b bad_index=%b",
                   $time, out_data.value, out_data.run_last, out_data.list_last,
                   out_data.bad_index);
          fail_count++;
        end
      end
    end
  end

  // Counts only cycles in which work is pending and neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (stim_q.size() == 0 && !in_valid && gathered_q.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d result words still expected", $time, gathered_q.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_word(OP_WRITE, 1, 0, '1, 1'b0);
    push_word(OP_WRITE, 2, 0, '0, 1'b0);
    push_word(OP_WRITE, 3, 0, 64'hA5A5_5A5A_F00F_0FF0, 1'b0);
    push_word(OP_WRITE, DEPTH, 0, {$urandom, $urandom}, 1'b0);
    push_word(OP_WRITE, DEPTH - 1, 0, {$urandom, $urandom}, 1'b0);
    push_word(OP_WRITE, DEPTH - 2, 0, {$urandom, $urandom}, 1'b0);
    // Writes to position zero or past the store are dropped and give no result.
    push_word(OP_WRITE, 0, 0, {$urandom, $urandom}, 1'b1);
    push_word(OP_WRITE, MAX_IDX, 127, {$urandom, $urandom}, 1'b0);
    push_word(OP_WRITE, DEPTH + 1, 0, {$urandom, $urandom}, 1'b1);
    push_word(OP_READ, 1, 0, '0, 1'b0);
    push_word(OP_READ, 1, 3, '0, 1'b1);
    push_word(OP_READ, 0, 4, '0, 1'b0);
    push_word(OP_READ, DEPTH - 2, 5, '0, 1'b1);
    push_word(OP_READ, MAX_IDX, 127, '1, 1'b1);
    push_word(OP_READ, DEPTH + 1, MAX_RUN, '0, 1'b0);
    push_word(OP_READ, DEPTH, 1, '0, 1'b1);
    push_word(OP_WRITE, 4, 0, {$urandom, $urandom}, 1'b1);
    push_word(OP_READ, 3, 2, '0, 1'b1);

    // A default of zero acts as a run of one; 127 saturates to a full run.
    wait_idle(8);
    set_default_run(7'd0);
    push_word(OP_READ, 2, 0, '0, 1'b1);
    wait_idle(8);
    set_default_run(7'd127);
    push_word(OP_READ, 2000, 0, '0, 1'b0);
    push_word(OP_READ, DEPTH - 2, 0, '0, 1'b1);

    random_phase(58, 7'd64, 35, 55);
    random_phase(58, 7'($urandom_range(63, 2)), 35, 55);
    random_phase(58, 7'd1, 55, 35);
    random_phase(58, 7'd127, 55, 35);
    random_phase(58, 7'($urandom_range(127, 0)), 0, 0);
    random_phase(58, 7'd16, 0, 0);

    wait_idle(20);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
